FILE: rtl/hidrr_pkg.sv
// hidrr_pkg: shared types, constants and the device-info table for the
// hid++ request responder; no dependencies
`default_nettype none

package hidrr_pkg;

    localparam logic [7:0] RID_SHORT   = 8'h10;
    localparam logic [7:0] RID_LONG    = 8'h11;
    localparam logic [7:0] RID_REPLY_S = 8'h50;
    localparam logic [7:0] RID_REPLY_L = 8'h51;
    localparam logic [7:0] SUB_REG_RD  = 8'h81;

    localparam logic [15:0] REG_BATTERY = 16'h0d00;
    localparam logic [15:0] REG_FW_HI   = 16'hf101;
    localparam logic [15:0] REG_FW_LO   = 16'hf102;

    localparam logic [15:0] FEAT_ROOT     = 16'h0000;
    localparam logic [15:0] FEAT_DEVINFO  = 16'h0003;
    localparam logic [15:0] FEAT_BATTERY  = 16'h1000;
    localparam logic [15:0] FEAT_WIRELESS = 16'h1d4b;

    localparam logic [7:0] BATT_V1_LEVEL  = 8'd50;
    localparam logic [7:0] ROOT_VERSION   = 8'd2;
    localparam logic [7:0] BATT_V2_LEVEL  = 8'd80;
    localparam logic [7:0] BATT_V2_NEXT   = 8'd70;
    localparam logic [7:0] BATT_V2_STATUS = 8'd2;

    localparam int unsigned IDX_W = 5;
    localparam logic [IDX_W-1:0] IDX_LAST_S   = 5'd9;
    localparam logic [IDX_W-1:0] IDX_LAST_L   = 5'd21;
    localparam logic [IDX_W-1:0] IDX_DEVINFO0 = 5'd5;
    localparam logic [IDX_W-1:0] IDX_DEVINFO1 = 5'd16;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_FW   = 1'b1
    } t_reg_idx;

    // one queued reply descriptor
    typedef struct packed {
        logic [7:0] dev_index;
        logic [7:0] rf_prefix;
        logic [7:0] sub_id;
        logic [7:0] reg_address;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
        logic       long_frame;
        logic       dev_info;
    } t_job;

    function automatic logic [7:0] info_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h61;
            4'd2:    v = 8'h62;
            4'd3:    v = 8'h63;
            4'd4:    v = 8'h33;
            4'd5:    v = 8'h44;
            4'd6:    v = 8'h01;
            4'd7:    v = 8'h01;
            4'd8:    v = 8'h00;
            4'd9:    v = 8'h4b;
            4'd10:   v = 8'h53;
            4'd11:   v = 8'h42;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hidrr_front.sv
// hidrr_front: accepts a request and classifies it into a reply descriptor
// depends on hidrr_pkg
`default_nettype none

module hidrr_front (
    input  wire logic              i_protocol_mode,
    input  wire logic [31:0]       i_firmware_word,
    input  wire logic [7:0]        i_dev_index,
    input  wire logic [7:0]        i_report_id,
    input  wire logic [7:0]        i_rf_prefix,
    input  wire logic [7:0]        i_sub_id,
    input  wire logic [7:0]        i_reg_address,
    input  wire logic [7:0]        i_param_low,
    input  wire logic [7:0]        i_param_high,
    input  wire logic [7:0]        i_ping_value,
    output hidrr_pkg::t_job        o_job,
    output logic                   o_reply
);

    logic [15:0] w_reg_key;
    logic [15:0] w_feat_key;
    logic        w_reg_rd;

    assign w_reg_key  = {i_reg_address, i_param_low};
    assign w_feat_key = {i_param_low, i_param_high};
    assign w_reg_rd   = (i_sub_id == hidrr_pkg::SUB_REG_RD);

    always_comb begin
        o_job             = '0;
        o_job.dev_index   = i_dev_index;
        o_job.rf_prefix   = i_rf_prefix;
        o_job.sub_id      = i_sub_id;
        o_job.reg_address = i_reg_address;
        o_reply           = 1'b0;
        if (!i_protocol_mode) begin
            o_reply = (i_report_id == hidrr_pkg::RID_SHORT) ||
                      (i_report_id == hidrr_pkg::RID_LONG);
            if (w_reg_rd && w_reg_key == hidrr_pkg::REG_BATTERY) begin
                o_job.b5 = hidrr_pkg::BATT_V1_LEVEL;
            end else if (w_reg_rd && w_reg_key == hidrr_pkg::REG_FW_HI) begin
                o_job.b5 = i_param_low;
                o_job.b6 = i_firmware_word[31:24];
                o_job.b7 = i_firmware_word[23:16];
            end else if (w_reg_rd && w_reg_key == hidrr_pkg::REG_FW_LO) begin
                o_job.b5 = i_param_low;
                o_job.b6 = i_firmware_word[15:8];
                o_job.b7 = i_firmware_word[7:0];
            end else begin
                o_job.long_frame = (i_report_id == hidrr_pkg::RID_LONG);
            end
        end else if (i_report_id == hidrr_pkg::RID_SHORT) begin
            case (w_feat_key)
                hidrr_pkg::FEAT_ROOT: begin
                    o_reply  = 1'b1;
                    o_job.b5 = hidrr_pkg::ROOT_VERSION;
                    o_job.b7 = i_ping_value;
                end
                hidrr_pkg::FEAT_DEVINFO: begin
                    o_reply          = 1'b1;
                    o_job.long_frame = 1'b1;
                    o_job.dev_info   = 1'b1;
                end
                hidrr_pkg::FEAT_BATTERY: begin
                    o_reply          = 1'b1;
                    o_job.long_frame = 1'b1;
                    o_job.b5         = hidrr_pkg::BATT_V2_LEVEL;
                    o_job.b6         = hidrr_pkg::BATT_V2_NEXT;
                    o_job.b7         = hidrr_pkg::BATT_V2_STATUS;
                end
                hidrr_pkg::FEAT_WIRELESS: begin
                    o_reply          = 1'b1;
                    o_job.long_frame = 1'b1;
                end
                default: begin
                    o_reply = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hidrr_queue.sv
// hidrr_queue: two-entry descriptor queue between front and back
// depends on hidrr_pkg
`default_nettype none

module hidrr_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire hidrr_pkg::t_job i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output hidrr_pkg::t_job      o_job,
    output logic                 o_empty
);

    hidrr_pkg::t_job r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/hidrr_back.sv
// hidrr_back: walks a descriptor byte by byte into the output register
// and appends the running checksum; depends on hidrr_pkg
`default_nettype none

module hidrr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hidrr_pkg::t_job i_job,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_tvalid,
    input  wire logic            i_tready,
    output logic [7:0]           o_tdata,
    output logic                 o_tlast
);

    hidrr_pkg::t_job                 r_job;
    logic                            r_busy;
    logic [hidrr_pkg::IDX_W-1:0]     r_idx;
    logic [7:0]                      r_sum;
    logic                            r_out_valid;
    logic [7:0]                      r_out_byte;
    logic                            r_out_last;

    logic                            w_advance;
    logic                            w_emit;
    logic                            w_at_last;
    logic [hidrr_pkg::IDX_W-1:0]     w_last_idx;
    logic [hidrr_pkg::IDX_W-1:0]     w_info_off;
    logic [7:0]                      w_byte;

    assign w_advance  = !r_out_valid || i_tready;
    assign w_emit     = r_busy && w_advance;
    assign w_last_idx = r_job.long_frame ? hidrr_pkg::IDX_LAST_L : hidrr_pkg::IDX_LAST_S;
    assign w_at_last  = (r_idx == w_last_idx);
    assign w_info_off = r_idx - hidrr_pkg::IDX_DEVINFO0;
    assign o_pop      = !i_empty && (!r_busy || (w_emit && w_at_last));

    always_comb begin
        w_byte = 8'h00;
        if (w_at_last) begin
            w_byte = 8'h00 - r_sum;
        end else if (r_job.dev_info && r_idx >= hidrr_pkg::IDX_DEVINFO0 &&
                     r_idx <= hidrr_pkg::IDX_DEVINFO1) begin
            w_byte = hidrr_pkg::info_byte(w_info_off[3:0]);
        end else begin
            case (r_idx)
                5'd0:    w_byte = r_job.dev_index;
                5'd1:    w_byte = r_job.long_frame ? hidrr_pkg::RID_REPLY_L
                                                   : hidrr_pkg::RID_REPLY_S;
                5'd2:    w_byte = r_job.rf_prefix;
                5'd3:    w_byte = r_job.sub_id;
                5'd4:    w_byte = r_job.reg_address;
                5'd5:    w_byte = r_job.b5;
                5'd6:    w_byte = r_job.b6;
                5'd7:    w_byte = r_job.b7;
                default: w_byte = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_sum       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= w_emit;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_sum  <= 8'h00;
            end else if (w_emit) begin
                r_idx <= r_idx + 5'd1;
                r_sum <= r_sum + w_byte;
                if (w_at_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= w_last_idx)
        else $error("byte index past end of frame");
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_idx == '0 && r_sum == 8'h00))
        else $error("frame started with stale index or checksum");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && !i_tready) |=> (o_tvalid && $stable(o_tdata) && $stable(o_tlast)))
        else $error("output changed while stalled");

endmodule

`default_nettype wire

FILE: rtl/hidrr_top_note.sv
// hidrr_cfg: apb register file holding protocol mode and firmware word
// depends on hidrr_pkg
`default_nettype none

module hidrr_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic             o_protocol_mode,
    output logic [31:0]      o_firmware_word
);

    logic        r_protocol_mode;
    logic [31:0] r_firmware_word;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol_mode <= 1'b0;
            r_firmware_word <= 32'h0;
        end else if (w_wr) begin
            case (hidrr_pkg::t_reg_idx'(paddr[2]))
                hidrr_pkg::REG_MODE: r_protocol_mode <= pwdata[0];
                hidrr_pkg::REG_FW:   r_firmware_word <= pwdata;
                default:             r_protocol_mode <= r_protocol_mode;
            endcase
        end
    end

    always_comb begin
        case (hidrr_pkg::t_reg_idx'(paddr[2]))
            hidrr_pkg::REG_MODE: prdata = {31'h0, r_protocol_mode};
            hidrr_pkg::REG_FW:   prdata = r_firmware_word;
            default:             prdata = 32'h0;
        endcase
    end

    assign o_protocol_mode = r_protocol_mode;
    assign o_firmware_word = r_firmware_word;

endmodule

`default_nettype wire

FILE: rtl/hidpp_request_responder.sv
// hidpp_request_responder: top level, front classifier, descriptor queue,
// byte generator and apb registers; depends on hidrr_pkg and submodules
//
//  channel   dir  handshake            payload
//  s stream  in   s_tvalid/s_tready    64-bit request bytes
//  m stream  out  m_tvalid/m_tready    reply byte, tlast on checksum
//  apb       in   psel/penable/pready  mode at 0x0, firmware word at 0x4
//
// a request is classified in its accept cycle and queued (two entries)
// a reply of 10 or 22 bytes leaves one byte per cycle while m_tready is high,
// after queue, job and output registers; the byte generator sets the pace
// requests with no reply are consumed without output
// reset is synchronous; output stalls back up through the queue only
`default_nettype none

module hidpp_request_responder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // dev_index, report_id, rf_prefix, sub_id, reg_address, param_low,
    // param_high, ping_value (8 bits each, from bit 0 up)
    input  wire logic [63:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // resp_byte
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic            w_protocol_mode;
    logic [31:0]     w_firmware_word;
    hidrr_pkg::t_job w_front_job;
    hidrr_pkg::t_job w_queue_job;
    logic            w_reply;
    logic            w_full;
    logic            w_empty;
    logic            w_pop;
    logic            w_push;

    hidrr_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_protocol_mode (w_protocol_mode),
        .o_firmware_word (w_firmware_word)
    );

    hidrr_front u_front (
        .i_protocol_mode (w_protocol_mode),
        .i_firmware_word (w_firmware_word),
        .i_dev_index     (i_s_tdata[7:0]),
        .i_report_id     (i_s_tdata[15:8]),
        .i_rf_prefix     (i_s_tdata[23:16]),
        .i_sub_id        (i_s_tdata[31:24]),
        .i_reg_address   (i_s_tdata[39:32]),
        .i_param_low     (i_s_tdata[47:40]),
        .i_param_high    (i_s_tdata[55:48]),
        .i_ping_value    (i_s_tdata[63:56]),
        .o_job           (w_front_job),
        .o_reply         (w_reply)
    );

    assign o_s_tready = !w_full;
    assign w_push     = i_s_tvalid && o_s_tready && w_reply;

    hidrr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_queue_job),
        .o_empty (w_empty)
    );

    hidrr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_queue_job),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
